@@ design/assert_macros.svh @@
// assertion macros shared by the spectrum hold design
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is switched off while reset is asserted
`define SPMHD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// check that also holds during reset
`define SPMHD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ design/spmhd_pkg.sv @@
// shared types and constants for the spectrum max-hold trace with decay
// no dependencies; imported by spectrum_max_hold_decay, spmhd_hold_update and the bench
`default_nettype none

package spmhd_pkg;

    // store depth default and register reset values
    localparam int DEFAULT_MAX_BINS = 2048;
    localparam logic [11:0] BINS_RESET = 12'd2048;
    localparam logic signed [15:0] MIN_FLOOR_RESET = -16'sd9000;

    // hold trace limits in hundredths of a dB
    localparam logic signed [15:0] HOLD_FLOOR = -16'sd20000;
    localparam logic signed [15:0] MIN_START = 16'sd20000;
    localparam logic signed [16:0] DECAY_STEP = 17'sd10;

    // divide by ten: q = (a * DIV10_MUL) >> DIV10_SHIFT, exact for a < 2^19
    localparam logic [18:0] DIV10_MUL = 19'd419431;
    localparam int DIV10_SHIFT = 22;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FLOOR = 8'd1;

    // action codes
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef struct packed {
        logic action;
        logic signed [15:0] power;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] held;
        logic [10:0] bin_index;
        logic frame_last;
        logic signed [15:0] peak_power;
        logic [10:0] peak_index;
        logic signed [15:0] min_power;
    } out_item_t;

endpackage

`default_nettype wire

@@ design/spectrum_max_hold_decay.sv @@
// a sample item is held in the second stage register, then in the result register
// one sample item per cycle, set by the store's read-modify-write, while results are taken and no sweep runs
// a clear item or a bin count change sweeps the store over the bins in use
// reset: synchronous, active low; a sweep of the reset bin count follows reset
// items are not accepted during a sweep; configuration writes always are
`default_nettype none

module spectrum_max_hold_decay #(
    parameter int MAX_BINS = spmhd_pkg::DEFAULT_MAX_BINS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire spmhd_pkg::in_item_t                  s_item,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output spmhd_pkg::out_item_t                      m_item,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [spmhd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [15:0]                          cfg_data
);
    import spmhd_pkg::*;

    `include "assert_macros.svh"

    localparam int IDX_W = $clog2(MAX_BINS);
    localparam int CNT_W = IDX_W + 1;

    // effective bin count: zero acts as one, clamp at the store depth
    function automatic logic [CNT_W-1:0] eff_of(input logic [11:0] raw);
        logic [CNT_W-1:0] r;
        if (raw == 12'd0) begin
            r = CNT_W'(1);
        end else if (32'(raw) > 32'(MAX_BINS)) begin
            r = CNT_W'(MAX_BINS);
        end else begin
            r = CNT_W'(raw);
        end
        return r;
    endfunction

    // configuration registers
    logic [11:0]        bins_reg, bins_next;
    logic signed [15:0] min_floor_reg, min_floor_next;

    // frame position and running statistics
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic signed [15:0] peak_reg, peak_next;
    logic [IDX_W-1:0]   pidx_reg, pidx_next;
    logic signed [15:0] min_reg, min_next;

    // clearing sweep
    logic               clr_busy_reg, clr_busy_next;
    logic [IDX_W-1:0]   clr_addr_reg, clr_addr_next;

    // second stage: item waiting for its stored value
    logic               s2_valid_reg, s2_valid_next;
    logic signed [15:0] s2_power_reg, s2_power_next;
    logic [IDX_W-1:0]   s2_idx_reg, s2_idx_next;
    logic               s2_last_reg, s2_last_next;
    logic signed [15:0] s2_peak_reg, s2_peak_next;
    logic [IDX_W-1:0]   s2_pidx_reg, s2_pidx_next;
    logic signed [15:0] s2_min_reg, s2_min_next;

    // last store write, forwarded to a read that missed it
    logic               fwd_valid_reg, fwd_valid_next;
    logic [IDX_W-1:0]   fwd_addr_reg, fwd_addr_next;
    logic signed [15:0] fwd_data_reg, fwd_data_next;

    // result register
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_item_reg, m_item_next;

    logic [CNT_W-1:0]   n_cur;
    logic [CNT_W-1:0]   n_wr;
    logic               cfg_wr;
    logic               bins_chg;
    logic               s_acc;
    logic               acc_sample;
    logic               acc_clear;
    logic               adv;
    logic [IDX_W-1:0]   i_cur;
    logic               last_cur;
    logic signed [15:0] peak_upd;
    logic [IDX_W-1:0]   pidx_upd;
    logic signed [15:0] min_upd;
    logic signed [15:0] min_rep;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic signed [15:0] ram_wdata;
    logic signed [15:0] ram_rdata;
    logic signed [15:0] held_old;
    logic signed [15:0] held_new;

    // handshakes
    assign cfg_ready = 1'b1;
    assign cfg_wr = cfg_valid && cfg_ready;
    assign n_cur = eff_of(bins_reg);
    assign n_wr = eff_of(cfg_data[11:0]);
    assign bins_chg = cfg_wr && (cfg_index == REG_BINS_IN_USE) && (n_wr != n_cur);

    assign adv = s2_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !clr_busy_reg && (!s2_valid_reg || adv);
    assign s_acc = s_valid && s_ready;
    assign acc_sample = s_acc && (s_item.action == ACT_SAMPLE);
    assign acc_clear = s_acc && (s_item.action == ACT_CLEAR);

    // bin position and frame statistics for the incoming sample
    always_comb begin
        i_cur = (CNT_W'(cnt_reg) >= n_cur) ? '0 : cnt_reg;
        last_cur = (CNT_W'(i_cur) + CNT_W'(1)) >= n_cur;
        if (s_item.power > peak_reg) begin
            peak_upd = s_item.power;
            pidx_upd = i_cur;
        end else begin
            peak_upd = peak_reg;
            pidx_upd = pidx_reg;
        end
        min_upd = (s_item.power < min_reg) ? s_item.power : min_reg;
        min_rep = (min_upd < min_floor_reg) ? min_floor_reg : min_upd;
    end

    // hold store and its update
    assign ram_we = clr_busy_reg || adv;
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : s2_idx_reg;
    assign ram_wdata = clr_busy_reg ? HOLD_FLOOR : held_new;

    spmhd_hold_ram #(
        .DEPTH(MAX_BINS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (acc_sample),
        .raddr (i_cur),
        .rdata (ram_rdata)
    );

    assign held_old = (fwd_valid_reg && (fwd_addr_reg == s2_idx_reg)) ? fwd_data_reg
                                                                      : ram_rdata;

    spmhd_hold_update u_upd (
        .held_old (held_old),
        .power    (s2_power_reg),
        .held_new (held_new)
    );

    // next-state logic
    always_comb begin
        bins_next = bins_reg;
        min_floor_next = min_floor_reg;
        cnt_next = cnt_reg;
        peak_next = peak_reg;
        pidx_next = pidx_reg;
        min_next = min_reg;
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        s2_valid_next = s2_valid_reg;
        s2_power_next = s2_power_reg;
        s2_idx_next = s2_idx_reg;
        s2_last_next = s2_last_reg;
        s2_peak_next = s2_peak_reg;
        s2_pidx_next = s2_pidx_reg;
        s2_min_next = s2_min_reg;
        fwd_valid_next = fwd_valid_reg;
        fwd_addr_next = fwd_addr_reg;
        fwd_data_next = fwd_data_reg;
        m_valid_next = m_valid_reg;
        m_item_next = m_item_reg;

        // clearing sweep over the bins in use
        if (clr_busy_reg) begin
            fwd_valid_next = 1'b0;
            if (CNT_W'(clr_addr_reg) == n_cur - CNT_W'(1)) begin
                clr_busy_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + IDX_W'(1);
            end
        end

        // result register
        if (adv) begin
            m_valid_next = 1'b1;
            m_item_next.held = held_new;
            m_item_next.bin_index = 11'(s2_idx_reg);
            m_item_next.frame_last = s2_last_reg;
            m_item_next.peak_power = s2_peak_reg;
            m_item_next.peak_index = 11'(s2_pidx_reg);
            m_item_next.min_power = s2_min_reg;
            fwd_valid_next = 1'b1;
            fwd_addr_next = s2_idx_reg;
            fwd_data_next = held_new;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        // second stage load
        if (adv) begin
            s2_valid_next = 1'b0;
        end
        if (acc_sample) begin
            s2_valid_next = 1'b1;
            s2_power_next = s_item.power;
            s2_idx_next = i_cur;
            s2_last_next = last_cur;
            s2_peak_next = last_cur ? peak_upd : '0;
            s2_pidx_next = last_cur ? pidx_upd : '0;
            s2_min_next = last_cur ? min_rep : '0;
            if (last_cur) begin
                cnt_next = '0;
                peak_next = HOLD_FLOOR;
                pidx_next = IDX_W'(n_cur >> 1);
                min_next = MIN_START;
            end else begin
                cnt_next = i_cur + IDX_W'(1);
                peak_next = peak_upd;
                pidx_next = pidx_upd;
                min_next = min_upd;
            end
        end

        // clear item starts a sweep
        if (acc_clear) begin
            clr_busy_next = 1'b1;
            clr_addr_next = '0;
        end

        // configuration writes
        if (cfg_wr && (cfg_index == REG_MIN_FLOOR)) begin
            min_floor_next = $signed(cfg_data);
        end
        if (cfg_wr && (cfg_index == REG_BINS_IN_USE)) begin
            bins_next = cfg_data[11:0];
        end
        if (bins_chg) begin
            cnt_next = '0;
            peak_next = HOLD_FLOOR;
            pidx_next = IDX_W'(n_wr >> 1);
            min_next = MIN_START;
            clr_busy_next = 1'b1;
            clr_addr_next = '0;
            fwd_valid_next = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bins_reg <= BINS_RESET;
            min_floor_reg <= MIN_FLOOR_RESET;
            cnt_reg <= '0;
            peak_reg <= HOLD_FLOOR;
            pidx_reg <= IDX_W'(eff_of(BINS_RESET) >> 1);
            min_reg <= MIN_START;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            s2_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            bins_reg <= bins_next;
            min_floor_reg <= min_floor_next;
            cnt_reg <= cnt_next;
            peak_reg <= peak_next;
            pidx_reg <= pidx_next;
            min_reg <= min_next;
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
            s2_valid_reg <= s2_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        s2_power_reg <= s2_power_next;
        s2_idx_reg <= s2_idx_next;
        s2_last_reg <= s2_last_next;
        s2_peak_reg <= s2_peak_next;
        s2_pidx_reg <= s2_pidx_next;
        s2_min_reg <= s2_min_next;
        fwd_addr_reg <= fwd_addr_next;
        fwd_data_reg <= fwd_data_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item = m_item_reg;

    // checks
    `SPMHD_ASSERT(a_no_item_in_sweep, aclk, aresetn, clr_busy_reg |-> !s_ready, "item accepted during sweep")
    `SPMHD_ASSERT(a_clear_starts_sweep, aclk, aresetn, acc_clear |=> clr_busy_reg, "clear item did not start a sweep")
    `SPMHD_ASSERT(a_no_write_clash, aclk, aresetn, clr_busy_reg |-> !s2_valid_reg, "sample pending during sweep")
    `SPMHD_ASSERT(a_held_floor, aclk, aresetn, m_valid |-> (m_item.held >= HOLD_FLOOR), "held below floor")
    `SPMHD_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> (!m_valid && clr_busy_reg), "reset did not idle the block")

endmodule

`default_nettype wire

@@ design/spmhd_hold_ram.sv @@
// hold store: single write port, single read port, registered read data
// depends on nothing but its parameters
`default_nettype none

module spmhd_hold_ram #(
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic signed [15:0]       wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic signed [15:0]            rdata
);

    logic signed [15:0] mem [DEPTH];
    logic signed [15:0] rdata_reg;

    // write and read, read data old on a same-address collision
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ design/spmhd_hold_update.sv @@
// per-bin held value update: slow rise toward a new peak or linear decay
// depends on spmhd_pkg
`default_nettype none

module spmhd_hold_update (
    input  wire logic signed [15:0] held_old,
    input  wire logic signed [15:0] power,
    output logic signed [15:0]      held_new
);
    import spmhd_pkg::*;

    logic signed [19:0] sum;
    logic [19:0]        mag;
    logic [37:0]        prod;
    logic [15:0]        quo;
    logic signed [15:0] rise;
    logic signed [16:0] dec;
    logic signed [15:0] fall;

    // rise: (9*h + p) / 10, truncated toward zero
    always_comb begin
        sum = (20'(held_old) <<< 3) + 20'(held_old) + 20'(power);
        mag = sum[19] ? 20'(-sum) : 20'(sum);
        prod = mag[18:0] * DIV10_MUL;
        quo = prod[DIV10_SHIFT+15:DIV10_SHIFT];
        rise = sum[19] ? -$signed(quo) : $signed(quo);
    end

    // fall: drop by the decay step, saturate at the floor
    always_comb begin
        dec = 17'(held_old) - DECAY_STEP;
        fall = (dec < 17'(HOLD_FLOOR)) ? HOLD_FLOOR : dec[15:0];
    end

    assign held_new = (power > held_old) ? rise : fall;

endmodule

`default_nettype wire

@@ bench/tb_spectrum_max_hold_decay.sv @@
// self-checking bench for the spectrum max-hold trace with decay
// drives bursty bin items and register writes, predicts every bin report in place
// depends on spmhd_pkg and spectrum_max_hold_decay
`timescale 1ns / 1ps

module tb_spectrum_max_hold_decay;
    import spmhd_pkg::*;

    localparam int MAX_BINS = DEFAULT_MAX_BINS;
    localparam int RANDOM_ITEMS = 950;
    localparam int MAX_REPORTED = 10;

    // register indexes that the block must ignore
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP = 8'd255;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_COMB, RX_LONG} rx_mode_e;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b1;
    out_item_t m_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // stimulus and expectations
    in_item_t pending_items[$];
    out_item_t bin_reports_due[$];
    int stim_count = 0;
    int mismatches = 0;

    // own copy of the hold trace
    logic signed [15:0] hold_mem [0:MAX_BINS-1];
    int bin_pos;
    int peak_val;
    int peak_pos;
    int low_val;
    logic [11:0] bins_raw;
    logic signed [15:0] floor_val;

    // sender burst shaping and receiver stall pattern
    int burst_left = 1;
    int gap_left = 0;
    logic [15:0] rx_tick = '0;
    rx_mode_e rx_mode = RX_OPEN;

    spectrum_max_hold_decay dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item(s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item(m_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic int effective_bins(input logic [11:0] raw);
        if (raw == 12'd0)
            return 1;
        if (raw > MAX_BINS)
            return MAX_BINS;
        return int'(raw);
    endfunction

    task automatic wipe_hold();
        for (int k = 0; k < MAX_BINS; k++)
            hold_mem[k] = HOLD_FLOOR;
    endtask

    task automatic restart_frame();
        bin_pos = 0;
        peak_val = HOLD_FLOOR;
        low_val = MIN_START;
        peak_pos = effective_bins(bins_raw) / 2;
    endtask

    task automatic reset_trace();
        bins_raw = BINS_RESET;
        floor_val = MIN_FLOOR_RESET;
        wipe_hold();
        restart_frame();
    endtask

    // register write as seen by the trace: a changed effective bin count clears and restarts
    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        bit changed;
        if (idx == REG_BINS_IN_USE) begin
            changed = effective_bins(data[11:0]) != effective_bins(bins_raw);
            bins_raw = data[11:0];
            if (changed) begin
                wipe_hold();
                restart_frame();
            end
        end else if (idx == REG_MIN_FLOOR) begin
            floor_val = data;
        end
    endtask

    // one accepted item: update the trace and queue the bin report it causes
    task automatic advance_hold_trace(input in_item_t it);
        int n;
        int idx;
        int p;
        int h;
        int mn;
        out_item_t r;
        n = effective_bins(bins_raw);
        if (it.action == ACT_CLEAR) begin
            wipe_hold();
            return;
        end
        p = it.power;
        idx = bin_pos;
        if (idx >= n)
            idx = 0;
        if (p > peak_val) begin
            peak_val = p;
            peak_pos = idx;
        end
        if (p < low_val)
            low_val = p;
        // slow rise toward a higher power, otherwise linear decay to the floor
        h = hold_mem[idx];
        if (p > h) begin
            h = (9 * h + p) / 10;
        end else begin
            h = h - DECAY_STEP;
            if (h < HOLD_FLOOR)
                h = HOLD_FLOOR;
        end
        hold_mem[idx] = h[15:0];
        r = '0;
        r.held = h[15:0];
        r.bin_index = idx[10:0];
        r.frame_last = (idx + 1) >= n;
        if (r.frame_last) begin
            mn = (low_val < floor_val) ? floor_val : low_val;
            r.peak_power = peak_val[15:0];
            r.peak_index = peak_pos[10:0];
            r.min_power = mn[15:0];
            restart_frame();
        end else begin
            bin_pos = idx + 1;
        end
        bin_reports_due.push_back(r);
    endtask

    task automatic compare_field(input string fname, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED)
                $display("mismatch on %s: expected %0d, got %0d", fname, want, got);
        end
    endtask

    // driver: bursts of random length with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                s_item <= pending_items.pop_front();
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern redrawn at random whenever the low byte of the tick counter wraps
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 16'd1;
        if (rx_tick[7:0] == 8'd0)
            rx_mode <= rx_mode_e'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN: m_ready <= 1'b1;
            RX_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
            RX_COMB: m_ready <= (rx_tick[2:0] != 3'd5) && (rx_tick[2:0] != 3'd6);
            default: m_ready <= (rx_tick[5:4] != 2'd0);
        endcase
    end

    // monitor: track writes and accepted items, check each bin report
    always @(posedge aclk) begin : monitor
        out_item_t want;
        if (!aresetn) begin
            reset_trace();
        end else begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (s_valid && s_ready)
                advance_hold_trace(s_item);
            if (m_valid && m_ready) begin
                if (bin_reports_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTED)
                        $display("unexpected bin report: held %0d, bin %0d",
                                 m_item.held, m_item.bin_index);
                end else begin
                    want = bin_reports_due.pop_front();
                    compare_field("held", want.held, m_item.held);
                    compare_field("bin_index", want.bin_index, m_item.bin_index);
                    compare_field("frame_last", want.frame_last, m_item.frame_last);
                    compare_field("peak_power", want.peak_power, m_item.peak_power);
                    compare_field("peak_index", want.peak_index, m_item.peak_index);
                    compare_field("min_power", want.min_power, m_item.min_power);
                end
            end
        end
    end

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || bin_reports_due.size() != 0);
    endtask

    // write only when idle, after any store sweep has had time to finish
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        wait_drained();
        repeat (effective_bins(bins_raw) + 16) @(posedge aclk);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_sample(input int p);
        in_item_t it;
        it.action = ACT_SAMPLE;
        it.power = p[15:0];
        pending_items.push_back(it);
        stim_count++;
    endtask

    task automatic push_clear();
        in_item_t it;
        it.action = ACT_CLEAR;
        it.power = 16'($urandom);
        pending_items.push_back(it);
        stim_count++;
    endtask

    // mostly near a per-phase level, with extremes and full-range values mixed in
    function automatic int draw_power(input int level);
        int p;
        case ($urandom_range(0, 9))
            0: p = -20000;
            1: p = 20000;
            2, 3: p = $urandom_range(0, 40000) - 20000;
            default: p = level + $urandom_range(0, 1000) - 500;
        endcase
        if (p < -20000)
            p = -20000;
        if (p > 20000)
            p = 20000;
        return p;
    endfunction

    initial begin : stimulus
        int level;
        int n;
        int count;
        int half;
        int pick;
        bit first;
        logic [15:0] bins_word;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: four-bin frames at the extremes
        cfg_write(REG_BINS_IN_USE, 16'd4);
        cfg_write(REG_MIN_FLOOR, 16'(-20000));
        // nothing above the floor: peak at the floor, index at half the bins
        repeat (4) push_sample(-20000);
        push_sample(20000);
        push_sample(-20000);
        push_sample(0);
        push_sample(-1);
        // every bin at the top: minimum stays at its start value
        repeat (4) push_sample(20000);
        push_clear();
        // repeated peak: first index wins
        push_sample(5);
        push_sample(5);
        push_sample(7);
        push_sample(7);
        // minimum raised to a high floor
        cfg_write(REG_MIN_FLOOR, 16'd20000);
        push_sample(-123);
        push_sample(456);
        push_sample(-20000);
        push_sample(20000);
        // zero bin count behaves as one bin
        cfg_write(REG_BINS_IN_USE, 16'd0);
        push_sample(100);
        push_sample(-100);
        push_sample(19999);
        cfg_write(REG_SPARE, 16'h0003);
        cfg_write(REG_TOP, 16'hffff);

        // random phases
        stim_count = 0;
        first = 1'b1;
        while (stim_count < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 12)
                bins_word = 16'($urandom_range(1, 16));
            else if (pick < 16)
                bins_word = 16'($urandom_range(17, 300));
            else if (pick == 16)
                bins_word = 16'd0;
            else if (pick == 17)
                bins_word = 16'd1;
            else if (pick == 18)
                case ($urandom_range(0, 2))
                    0: bins_word = 16'd2048;
                    1: bins_word = 16'd4095;
                    default: bins_word = 16'($urandom_range(2049, 4095));
                endcase
            else
                bins_word = {4'($urandom_range(0, 15)), bins_raw};
            cfg_write(REG_BINS_IN_USE, bins_word);
            if ($urandom_range(0, 1) == 0)
                case ($urandom_range(0, 3))
                    0: cfg_write(REG_MIN_FLOOR, 16'(-20000));
                    1: cfg_write(REG_MIN_FLOOR, 16'd20000);
                    2: cfg_write(REG_MIN_FLOOR, 16'(-9000));
                    default: cfg_write(REG_MIN_FLOOR, 16'($urandom_range(0, 40000) - 20000));
                endcase
            if ($urandom_range(0, 7) == 0)
                cfg_write(($urandom_range(0, 1) == 0) ? REG_SPARE : REG_TOP, 16'($urandom));

            // one or more frames at small counts, a partial frame at the largest
            n = effective_bins(bins_word[11:0]);
            if (n > 300) begin
                count = $urandom_range(20, 60);
            end else begin
                count = n * $urandom_range(1, 8);
                if (count > 200)
                    count = n;
                if (n <= 16)
                    count += $urandom_range(0, n - 1);
            end
            // keep the total near the planned item count
            if (count > RANDOM_ITEMS - stim_count)
                count = RANDOM_ITEMS - stim_count;
            level = $urandom_range(0, 40000) - 20000;
            half = (first || $urandom_range(0, 3) == 0) ? count / 2 : count;
            first = 1'b0;
            for (int k = 0; k < count; k++) begin
                // sender holds off until every report so far has come back
                if (k == half)
                    wait_drained();
                if (n <= 300 && $urandom_range(0, 29) == 0)
                    push_clear();
                else
                    push_sample(draw_power(level));
            end
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && bin_reports_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // overall limit on the run
    initial begin : watchdog
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
